// ===== hdl/lcdns_pkg.sv =====
// Package for the character LCD nibble sequencer.
// Holds request codes, byte selections, timing constants and the
// controller/datapath command and status structures. No dependencies.
package lcdns_pkg;

  // Request codes on the command field of an input beat.
  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_INS    = 3'd1,
    CMD_DATA   = 3'd2,
    CMD_GOTO   = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_GLYPH  = 3'd5,
    CMD_NUMBER = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_t;

  // Source of the byte that the next pair of strobes carries.
  typedef enum logic [3:0] {
    SEL_INIT33,
    SEL_INIT32,
    SEL_INIT28,
    SEL_DISP0C,
    SEL_CLR01,
    SEL_HOME80,
    SEL_RAW_INS,
    SEL_RAW_DATA,
    SEL_GOTO,
    SEL_CGRAM,
    SEL_DIGIT
  } sel_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_BASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_BASE = 2'd3;

  localparam logic [7:0] ROW0_RESET = 8'h00;
  localparam logic [7:0] ROW1_RESET = 8'h40;
  localparam logic [7:0] ROW2_RESET = 8'h14;
  localparam logic [7:0] ROW3_RESET = 8'h54;

  // Instruction bytes.
  localparam logic [7:0] BYTE_INIT33 = 8'h33;
  localparam logic [7:0] BYTE_INIT32 = 8'h32;
  localparam logic [7:0] BYTE_FUNC28 = 8'h28;
  localparam logic [7:0] BYTE_DISP0C = 8'h0C;
  localparam logic [7:0] BYTE_CLR01  = 8'h01;
  localparam logic [7:0] BYTE_HOME80 = 8'h80;

  // Settle times in milliseconds.
  localparam logic [5:0] SETTLE_POWER = 6'd40;
  localparam logic [5:0] SETTLE_INIT  = 6'd10;
  localparam logic [5:0] SETTLE_PULSE = 6'd2;

  // Reciprocal of ten: q = (t * RECIP10) >> RECIP_SHIFT is exact for 32-bit t.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // Digit index and count fields; wide enough for the largest digit limit.
  localparam int unsigned DIG_FIELD_W = 5;

  // Controller to datapath.
  typedef struct packed {
    logic                   load;
    logic                   div_mul;
    logic                   div_store;
    logic                   emit;
    sel_t                   sel;
    logic                   half;
    logic                   last;
    logic [DIG_FIELD_W-1:0] digit_idx;
    logic [7:0]             col_offset;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_t                   command;
    logic                   slot_high;
    logic                   glyph_row_zero;
    logic                   div_done;
    logic [DIG_FIELD_W-1:0] digit_count;
    logic                   out_free;
  } dp_stat_t;

endpackage

// ===== hdl/lcdns_req_if.sv =====
// Request channel interface of the character LCD nibble sequencer.
// Carries valid, ready and one request beat; uses lcdns_pkg for the code type.
interface lcdns_req_if;
  logic                valid;
  logic                ready;
  lcdns_pkg::cmd_t     command;
  logic [31:0]         value;
  logic [1:0]          row;
  logic [7:0]          column;
  logic [3:0]          slot;
  logic [2:0]          glyph_row;

  modport source (output valid, command, value, row, column, slot, glyph_row, input ready);
  modport sink   (input valid, command, value, row, column, slot, glyph_row, output ready);
endinterface

// ===== hdl/lcdns_strobe_if.sv =====
// Strobe channel interface of the character LCD nibble sequencer.
// Carries valid, ready and one enable-strobe beat. No dependencies.
interface lcdns_strobe_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic [5:0] settle_ms;
  logic       last;

  modport source (output valid, reg_select, nibble, settle_ms, last, input ready);
  modport sink   (input valid, reg_select, nibble, settle_ms, last, output ready);
endinterface

// ===== hdl/lcdns_dp.sv =====
// Datapath of the character LCD nibble sequencer: row base registers,
// request latch, divide-by-ten unit with digit store, and the strobe register.
// Depends on lcdns_pkg.
module lcdns_dp #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lcdns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_wdata,
  input  lcdns_pkg::cmd_t                   in_command,
  input  logic [31:0]                       in_value,
  input  logic [1:0]                        in_row,
  input  logic [7:0]                        in_column,
  input  logic [3:0]                        in_slot,
  input  logic [2:0]                        in_glyph_row,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_reg_select,
  output logic [3:0]                        out_nibble,
  output logic [5:0]                        out_settle_ms,
  output logic                              out_last,
  input  lcdns_pkg::dp_cmd_t                cmd,
  output lcdns_pkg::dp_stat_t               stat
);

  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

  logic [7:0]       row_base_r [4];
  lcdns_pkg::cmd_t  command_r;
  logic [7:0]       byte_r;
  logic [1:0]       row_r;
  logic [7:0]       column_r;
  logic [2:0]       slot_r;
  logic             slot_high_r;
  logic             grow_zero_r;
  logic [31:0]      t_r;
  logic [31:0]      q_r;
  logic [CNT_W-1:0] cnt_r;
  logic [3:0]       digits_r [MAX_DIGITS];
  logic [3:0]       digit_rd_r;
  logic             out_valid_r;
  logic             rs_r;
  logic [3:0]       nibble_r;
  logic [5:0]       settle_r;
  logic             last_r;

  logic [63:0]      prod;
  logic [31:0]      rem;
  logic [7:0]       addr;
  logic [7:0]       cur_byte;
  logic             cur_rs;
  logic [5:0]       cur_settle;

  // Row base registers, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_base_r[0] <= lcdns_pkg::ROW0_RESET;
      row_base_r[1] <= lcdns_pkg::ROW1_RESET;
      row_base_r[2] <= lcdns_pkg::ROW2_RESET;
      row_base_r[3] <= lcdns_pkg::ROW3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcdns_pkg::REG_ROW0_BASE: row_base_r[0] <= cfg_wdata;
        lcdns_pkg::REG_ROW1_BASE: row_base_r[1] <= cfg_wdata;
        lcdns_pkg::REG_ROW2_BASE: row_base_r[2] <= cfg_wdata;
        lcdns_pkg::REG_ROW3_BASE: row_base_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One divide step: the multiply is registered, then the remainder is stored.
  assign prod = 64'(t_r) * 64'(lcdns_pkg::RECIP10);
  assign rem  = t_r - (q_r << 3) - (q_r << 1);

  // Request latch, divider and digit store.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r   <= in_command;
      byte_r      <= in_value[7:0];
      row_r       <= in_row;
      column_r    <= in_column;
      slot_r      <= in_slot[2:0];
      slot_high_r <= in_slot[3];
      grow_zero_r <= (in_glyph_row == 3'd0);
      t_r         <= in_value;
      cnt_r       <= '0;
    end else if (cmd.div_mul) begin
      q_r <= 32'(prod >> lcdns_pkg::RECIP_SHIFT);
    end else if (cmd.div_store) begin
      digits_r[cnt_r[IDX_W-1:0]] <= rem[3:0];
      t_r                        <= q_r;
      cnt_r                      <= cnt_r + CNT_W'(1);
    end
    digit_rd_r <= digits_r[cmd.digit_idx[IDX_W-1:0]];
  end

  // Display address for a goto, with the column offset of a number digit.
  assign addr = row_base_r[row_r] + column_r + cmd.col_offset;

  // Byte, register select and settle time of the strobe being issued.
  always_comb begin
    cur_byte = lcdns_pkg::BYTE_HOME80;
    cur_rs   = 1'b0;
    unique case (cmd.sel)
      lcdns_pkg::SEL_INIT33:   cur_byte = lcdns_pkg::BYTE_INIT33;
      lcdns_pkg::SEL_INIT32:   cur_byte = lcdns_pkg::BYTE_INIT32;
      lcdns_pkg::SEL_INIT28:   cur_byte = lcdns_pkg::BYTE_FUNC28;
      lcdns_pkg::SEL_DISP0C:   cur_byte = lcdns_pkg::BYTE_DISP0C;
      lcdns_pkg::SEL_CLR01:    cur_byte = lcdns_pkg::BYTE_CLR01;
      lcdns_pkg::SEL_HOME80:   cur_byte = lcdns_pkg::BYTE_HOME80;
      lcdns_pkg::SEL_RAW_INS:  cur_byte = byte_r;
      lcdns_pkg::SEL_RAW_DATA: begin
        cur_byte = byte_r;
        cur_rs   = 1'b1;
      end
      lcdns_pkg::SEL_GOTO:     cur_byte = lcdns_pkg::BYTE_HOME80 | addr;
      lcdns_pkg::SEL_CGRAM:    cur_byte = {2'b01, slot_r, 3'b000};
      lcdns_pkg::SEL_DIGIT: begin
        cur_byte = {4'h3, digit_rd_r};
        cur_rs   = 1'b1;
      end
      default: ;
    endcase

    cur_settle = lcdns_pkg::SETTLE_PULSE;
    if (!cmd.half) begin
      case (cmd.sel) inside
        lcdns_pkg::SEL_INIT33: cur_settle = lcdns_pkg::SETTLE_POWER;
        lcdns_pkg::SEL_INIT32,
        lcdns_pkg::SEL_INIT28: cur_settle = lcdns_pkg::SETTLE_INIT;
        default: ;
      endcase
    end
  end

  // Strobe register: loaded when free, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      rs_r     <= cur_rs;
      nibble_r <= cmd.half ? cur_byte[3:0] : cur_byte[7:4];
      settle_r <= cur_settle;
      last_r   <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = rs_r;
  assign out_nibble     = nibble_r;
  assign out_settle_ms  = settle_r;
  assign out_last       = last_r;

  // Status back to the controller.
  always_comb begin
    stat                = '0;
    stat.command        = command_r;
    stat.slot_high      = slot_high_r;
    stat.glyph_row_zero = grow_zero_r;
    stat.div_done       = ((cnt_r != '0) && (t_r == 32'd0)) ||
                          (cnt_r == CNT_W'(MAX_DIGITS));
    stat.digit_count    = lcdns_pkg::DIG_FIELD_W'(cnt_r);
    stat.out_free       = !out_valid_r || out_ready;
  end

endmodule

// ===== hdl/lcdns_ctrl.sv =====
// Controller of the character LCD nibble sequencer: walks each request
// through its byte list and drives the datapath. Depends on lcdns_pkg.
module lcdns_ctrl #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lcdns_pkg::dp_stat_t  stat,
  output lcdns_pkg::dp_cmd_t   cmd
);

  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_MUL,
    ST_DIV_STORE,
    ST_EMIT
  } state_t;

  state_t           state_r;
  logic [2:0]       step_r;
  logic             half_r;
  logic [IDX_W-1:0] k_r;

  lcdns_pkg::sel_t  sel;
  logic             final_byte;
  logic             last_digit;
  logic [lcdns_pkg::DIG_FIELD_W-1:0] k_ext;

  assign k_ext      = lcdns_pkg::DIG_FIELD_W'(k_r);
  assign last_digit = (k_ext == stat.digit_count - lcdns_pkg::DIG_FIELD_W'(1));

  // Byte list of each request: selection and whether this is its final byte.
  always_comb begin
    sel        = lcdns_pkg::SEL_RAW_INS;
    final_byte = 1'b1;
    unique case (stat.command)
      lcdns_pkg::CMD_INIT: begin
        final_byte = (step_r == 3'd5);
        unique case (step_r)
          3'd0:    sel = lcdns_pkg::SEL_INIT33;
          3'd1:    sel = lcdns_pkg::SEL_INIT32;
          3'd2:    sel = lcdns_pkg::SEL_INIT28;
          3'd3:    sel = lcdns_pkg::SEL_DISP0C;
          3'd4:    sel = lcdns_pkg::SEL_CLR01;
          default: sel = lcdns_pkg::SEL_HOME80;
        endcase
      end
      lcdns_pkg::CMD_INS:  sel = lcdns_pkg::SEL_RAW_INS;
      lcdns_pkg::CMD_DATA: sel = lcdns_pkg::SEL_RAW_DATA;
      lcdns_pkg::CMD_GOTO: sel = lcdns_pkg::SEL_GOTO;
      lcdns_pkg::CMD_CLEAR: begin
        final_byte = (step_r != 3'd0);
        sel        = (step_r == 3'd0) ? lcdns_pkg::SEL_CLR01 : lcdns_pkg::SEL_HOME80;
      end
      lcdns_pkg::CMD_GLYPH: begin
        final_byte = (step_r != 3'd0);
        sel        = (step_r == 3'd0) ? lcdns_pkg::SEL_CGRAM : lcdns_pkg::SEL_RAW_DATA;
      end
      lcdns_pkg::CMD_NUMBER: begin
        final_byte = step_r[0] && last_digit;
        sel        = step_r[0] ? lcdns_pkg::SEL_DIGIT : lcdns_pkg::SEL_GOTO;
      end
      default: ;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == ST_IDLE) && in_valid;
    cmd.div_mul    = (state_r == ST_DIV_MUL) && !stat.div_done;
    cmd.div_store  = (state_r == ST_DIV_STORE);
    cmd.emit       = (state_r == ST_EMIT) && stat.out_free;
    cmd.sel        = sel;
    cmd.half       = half_r;
    cmd.last       = final_byte && half_r;
    cmd.digit_idx  = k_ext;
    cmd.col_offset = (stat.command == lcdns_pkg::CMD_NUMBER) ?
                     8'(stat.digit_count - lcdns_pkg::DIG_FIELD_W'(1) - k_ext) : 8'd0;
  end

  assign in_ready = (state_r == ST_IDLE);

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 3'd0;
      half_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          half_r <= 1'b0;
          k_r    <= '0;
          // A glyph row other than the first skips the CGRAM address byte.
          step_r <= ((stat.command == lcdns_pkg::CMD_GLYPH) && !stat.glyph_row_zero) ?
                    3'd1 : 3'd0;
          unique case (stat.command) inside
            lcdns_pkg::CMD_INIT,
            lcdns_pkg::CMD_INS,
            lcdns_pkg::CMD_DATA,
            lcdns_pkg::CMD_GOTO,
            lcdns_pkg::CMD_CLEAR: state_r <= ST_EMIT;
            lcdns_pkg::CMD_GLYPH: begin
              // A slot beyond the eight custom glyphs gives no strobes.
              if (stat.slot_high) begin
                state_r <= ST_IDLE;
              end else begin
                state_r <= ST_EMIT;
              end
            end
            lcdns_pkg::CMD_NUMBER: state_r <= ST_DIV_MUL;
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_DIV_MUL: begin
          state_r <= stat.div_done ? ST_EMIT : ST_DIV_STORE;
        end
        ST_DIV_STORE: begin
          state_r <= ST_DIV_MUL;
        end
        ST_EMIT: begin
          if (stat.out_free) begin
            if (!half_r) begin
              half_r <= 1'b1;
            end else begin
              half_r <= 1'b0;
              if (final_byte) begin
                state_r <= ST_IDLE;
              end else begin
                step_r <= step_r + 3'd1;
                if ((stat.command == lcdns_pkg::CMD_NUMBER) && step_r[0]) begin
                  k_r <= k_r + IDX_W'(1);
                end
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer.
// Instantiates lcdns_ctrl and lcdns_dp; uses lcdns_pkg and both channel interfaces.
//
// Usage: a request beat on in_ch (init, instruction byte, data byte, goto,
// clear, glyph row or decimal number) becomes a run of enable-strobe beats
// on out_ch, high nibble first, each with register select, settle time in
// milliseconds and a last flag on the final strobe of the request. The user
// must write row base addresses through cfg_we/cfg_index/cfg_wdata only
// while idle; the block does not enforce this. Timing: in_ch.ready is high
// only between requests. A request is latched and decoded before its first
// strobe is registered; after that one strobe a cycle while out_ch.ready
// stays high. A number first runs the divide-by-ten unit for each digit (a
// registered multiply, then a remainder store). The next request is taken
// the cycle after the last strobe is registered. Reset returns the controller
// to idle, drops out_ch.valid and restores the row bases to 0, 64, 20 and
// 84. When the receiver stalls, the strobe is held unchanged in the output
// register and the sequencer waits.
module char_lcd_nibble_sequencer #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcdns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_wdata,
  lcdns_req_if.sink                       in_ch,
  lcdns_strobe_if.source                  out_ch
);

  lcdns_pkg::dp_cmd_t  dp_cmd;
  lcdns_pkg::dp_stat_t dp_stat;

  // Sequencing control.
  lcdns_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Registers, divider and strobe output.
  lcdns_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_command     (in_ch.command),
    .in_value       (in_ch.value),
    .in_row         (in_ch.row),
    .in_column      (in_ch.column),
    .in_slot        (in_ch.slot),
    .in_glyph_row   (in_ch.glyph_row),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_reg_select (out_ch.reg_select),
    .out_nibble     (out_ch.nibble),
    .out_settle_ms  (out_ch.settle_ms),
    .out_last       (out_ch.last),
    .cmd            (dp_cmd),
    .stat           (dp_stat)
  );

endmodule

// ===== hdl/lcdns_checker.sv =====
// Port-level checks for the character LCD nibble sequencer, bound to the
// top level. Depends only on the top level's ports.
module lcdns_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_reg_select,
  input logic [3:0] out_nibble,
  input logic [5:0] out_settle_ms,
  input logic       out_last
);

  // A stalled strobe beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nibble) &&
    $stable(out_reg_select) && $stable(out_settle_ms) && $stable(out_last))
    else $error("strobe beat changed while stalled");

  // Requests are worked one at a time: ready drops after a request is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  // Only the three settle times exist.
  a_settle_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_settle_ms == 6'd2) || (out_settle_ms == 6'd10) ||
    (out_settle_ms == 6'd40))
    else $error("unexpected settle time");

  // The power-up wait belongs only to the high nibble of the first 0x33.
  a_power_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_settle_ms == 6'd40) |-> !out_reg_select &&
    (out_nibble == 4'h3) && !out_last)
    else $error("power-up wait on the wrong strobe");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_reg_select (out_ch.reg_select),
  .out_nibble     (out_ch.nibble),
  .out_settle_ms  (out_ch.settle_ms),
  .out_last       (out_ch.last)
);
